### rtl/core/zcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcm_pkg: shared types and constants of the zero crossing marker
// Sizes of the raster, the sample format, the shade divider and the job
// queue, the configuration register indexes and the structs between units.
// ----------------------------------------------------------------------------
package zcm_pkg;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned MIN_DIM       = 3;

  localparam int unsigned COL_BITS      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_BITS      = 11;
  localparam int unsigned BAND_BITS     = 15;
  localparam int unsigned CFG_DATA_BITS = 15;
  localparam int unsigned CFG_IDX_BITS  = 2;

  localparam int unsigned SHADE_BITS    = 8;
  localparam int unsigned DIV_STEPS     = SHADE_BITS;
  localparam int unsigned DEN_BITS      = BAND_BITS + 1;
  localparam int unsigned NUM_BITS      = DEN_BITS + 1;
  localparam int unsigned REM_BITS      = DEN_BITS + SHADE_BITS;

  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  localparam logic [31:0] COLOR_WHITE   = 32'hffff_ffff;
  localparam logic [31:0] COLOR_ALPHA   = 32'hff00_0000;
  localparam logic [SHADE_BITS-1:0] SHADE_FULL = '1;

  localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = 11'd480;
  localparam logic [BAND_BITS-1:0] BAND_RESET   = 15'd256;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ZERO_BAND    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_BITS-1:0]  width;
    logic [DIM_BITS-1:0]  height;
    logic [BAND_BITS-1:0] band;
  } cfg_t;

  // One interior pixel handed from the window logic to the shading unit.
  typedef struct packed {
    logic [COL_BITS-1:0]    x;
    logic [ROW_BITS-1:0]    y;
    logic                   white;
    logic [SAMPLE_BITS-1:0] center;
  } job_t;

  // Clamps a written frame dimension into MIN_DIM..max_dim.
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] value,
                                                    input logic [DIM_BITS-1:0] max_dim);
    logic [DIM_BITS-1:0] res;
    if (value < DIM_BITS'(MIN_DIM)) begin
      res = DIM_BITS'(MIN_DIM);
    end else if (value > max_dim) begin
      res = max_dim;
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/zcm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcm_front: raster tracking, line stores and 3x3 window
// Accepts samples, keeps the two previous rows in memories, slides the
// window and classifies every interior pixel into a job for the queue.
// ----------------------------------------------------------------------------
module zcm_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire zcm_pkg::cfg_t                  cfg_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [zcm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic                           frame_start_i,
  input  wire logic [zcm_pkg::FIFO_CNT_BITS-1:0] fifo_count_i,
  output logic                                push_o,
  output zcm_pkg::job_t                       job_o
);
  import zcm_pkg::*;

  logic                       accept;
  logic [FIFO_CNT_BITS:0]     credit;

  logic [COL_BITS-1:0]        col_q, col_d, col_start, col_cur;
  logic [ROW_BITS-1:0]        row_q, row_d, row_start, row_cur;
  logic [DIM_BITS-1:0]        col_inc, row_inc;

  logic [SAMPLE_BITS-1:0]     mid_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0]     top_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0]     mid_rd_q, top_rd_q, byp_data_q;
  logic                       byp_hit_q;
  logic                       wb_valid_q;
  logic [COL_BITS-1:0]        wb_addr_q;

  logic                       s1_valid_q;
  logic [SAMPLE_BITS-1:0]     s1_cur_q;
  logic [COL_BITS-1:0]        s1_col_q;
  logic [ROW_BITS-1:0]        s1_row_q;

  logic [SAMPLE_BITS-1:0]     win_c1_q [3];
  logic [SAMPLE_BITS-1:0]     win_c2_q [3];
  logic [SAMPLE_BITS-1:0]     top_eff;
  logic [SAMPLE_BITS-1:0]     pts [5];
  logic [4:0]                 pos, neg;

  // A sample is taken only if the job it may cause is sure to find room.
  assign credit     = (FIFO_CNT_BITS+1)'(fifo_count_i) + (FIFO_CNT_BITS+1)'(s1_valid_q);
  assign in_stall_o = credit >= (FIFO_CNT_BITS+1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col_start = frame_start_i ? '0 : col_q;
    row_start = frame_start_i ? '0 : row_q;
    col_cur   = ({1'b0, col_start} >= cfg_i.width)  ? '0 : col_start;
    row_cur   = ({1'b0, row_start} >= cfg_i.height) ? '0 : row_start;
    col_inc   = {1'b0, col_cur} + DIM_BITS'(1);
    row_inc   = {1'b0, row_cur} + DIM_BITS'(1);
    if (col_inc >= cfg_i.width) begin
      col_d = '0;
      row_d = (row_inc >= cfg_i.height) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      col_d = col_inc[COL_BITS-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q <= accept;
      wb_valid_q <= accept;
    end
  end

  // The row above is written back in the cycle after its read; a read of that
  // same column in the write-back cycle takes the bypass value instead.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_mem[col_cur] <= sample_i;
      mid_rd_q         <= mid_mem[col_cur];
      top_rd_q         <= top_mem[col_cur];
      byp_hit_q        <= wb_valid_q && (wb_addr_q == col_cur);
      byp_data_q       <= mid_rd_q;
      wb_addr_q        <= col_cur;
      s1_cur_q         <= sample_i;
      s1_col_q         <= col_cur;
      s1_row_q         <= row_cur;
    end
    if (wb_valid_q) begin
      top_mem[wb_addr_q] <= mid_rd_q;
    end
  end

  assign top_eff = byp_hit_q ? byp_data_q : top_rd_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win_c1_q    <= win_c2_q;
      win_c2_q[0] <= top_eff;
      win_c2_q[1] <= mid_rd_q;
      win_c2_q[2] <= s1_cur_q;
    end
  end

  // Centre and the four diagonal corners of the window after this shift.
  always_comb begin
    pts[0] = win_c2_q[1];
    pts[1] = win_c1_q[0];
    pts[2] = win_c1_q[2];
    pts[3] = top_eff;
    pts[4] = s1_cur_q;
    for (int i = 0; i < 5; i++) begin
      neg[i] = pts[i][SAMPLE_BITS-1];
      pos[i] = !pts[i][SAMPLE_BITS-1] && (pts[i] != '0);
    end
  end

  assign push_o = s1_valid_q && (s1_row_q >= ROW_BITS'(2)) && (s1_col_q >= COL_BITS'(2));

  always_comb begin
    job_o.x      = s1_col_q - COL_BITS'(1);
    job_o.y      = s1_row_q - ROW_BITS'(1);
    job_o.white  = (&pos) || (&neg);
    job_o.center = win_c2_q[1];
  end

endmodule
`default_nettype wire

### rtl/core/zcm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcm_fifo: job queue between window logic and shading unit
// A small first-in first-out buffer of classified pixels with a fill count.
// ----------------------------------------------------------------------------
module zcm_fifo (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire zcm_pkg::job_t                    push_data_i,
  input  wire logic                             pop_i,
  output zcm_pkg::job_t                         pop_data_o,
  output logic                                  empty_o,
  output logic [zcm_pkg::FIFO_CNT_BITS-1:0]     count_o
);
  import zcm_pkg::*;

  job_t                     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] count_q;
  logic                     do_pop;

  assign empty_o    = (count_q == '0);
  assign count_o    = count_q;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + FIFO_CNT_BITS'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - FIFO_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/core/zcm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcm_back: shade computation and result register
// Saturates the offset centre sample and divides 255*num by 2*band in a
// pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module zcm_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire zcm_pkg::cfg_t                  cfg_i,
  input  wire zcm_pkg::job_t                  job_i,
  input  wire logic                           fifo_empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [zcm_pkg::COL_BITS-1:0]        pixel_x_o,
  output logic [zcm_pkg::ROW_BITS-1:0]        pixel_y_o,
  output logic [31:0]                         color_o
);
  import zcm_pkg::*;

  logic                       adv;
  logic [DEN_BITS-1:0]        den;
  logic signed [NUM_BITS-1:0] num;
  logic                       ld_div;
  logic [SHADE_BITS-1:0]      ld_shade;
  logic [REM_BITS-1:0]        ld_rem;

  logic                       st_valid_q [DIV_STEPS+1];
  logic [COL_BITS-1:0]        st_x_q     [DIV_STEPS+1];
  logic [ROW_BITS-1:0]        st_y_q     [DIV_STEPS+1];
  logic                       st_white_q [DIV_STEPS+1];
  logic                       st_div_q   [DIV_STEPS+1];
  logic [SHADE_BITS-1:0]      st_shade_q [DIV_STEPS+1];
  logic [REM_BITS-1:0]        st_rem_q   [DIV_STEPS+1];

  logic [REM_BITS-1:0]        nx_rem   [1:DIV_STEPS];
  logic [SHADE_BITS-1:0]      nx_shade [1:DIV_STEPS];
  logic [REM_BITS-1:0]        dsh      [1:DIV_STEPS];

  logic                       out_valid_q;
  logic [COL_BITS-1:0]        out_x_q;
  logic [ROW_BITS-1:0]        out_y_q;
  logic [31:0]                out_color_q;

  // The whole pipeline moves together unless the result register is held.
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !fifo_empty_i;

  assign den = {cfg_i.band, 1'b0};
  assign num = $signed({job_i.center[SAMPLE_BITS-1], job_i.center})
             + $signed({2'b00, cfg_i.band});

  always_comb begin
    ld_div   = 1'b0;
    ld_shade = '0;
    if (num[NUM_BITS-1] || (num == '0)) begin
      ld_shade = '0;
    end else if ($unsigned(num) >= {1'b0, den}) begin
      ld_shade = SHADE_FULL;
    end else begin
      ld_div = 1'b1;
    end
    // 255 * num as a shift and a subtract; num is below den here.
    ld_rem = {num[DEN_BITS-1:0], {SHADE_BITS{1'b0}}}
           - {{SHADE_BITS{1'b0}}, num[DEN_BITS-1:0]};
  end

  always_comb begin
    for (int i = 1; i <= DIV_STEPS; i++) begin
      dsh[i]      = REM_BITS'(den) << (DIV_STEPS - i);
      nx_rem[i]   = st_rem_q[i-1];
      nx_shade[i] = st_shade_q[i-1];
      if (st_div_q[i-1] && (st_rem_q[i-1] >= dsh[i])) begin
        nx_rem[i]                 = st_rem_q[i-1] - dsh[i];
        nx_shade[i][DIV_STEPS-i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        st_valid_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      st_valid_q[0] <= !fifo_empty_i;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        st_valid_q[i] <= st_valid_q[i-1];
      end
      out_valid_q <= st_valid_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_x_q[0]     <= job_i.x;
      st_y_q[0]     <= job_i.y;
      st_white_q[0] <= job_i.white;
      st_div_q[0]   <= ld_div;
      st_shade_q[0] <= ld_shade;
      st_rem_q[0]   <= ld_rem;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        st_x_q[i]     <= st_x_q[i-1];
        st_y_q[i]     <= st_y_q[i-1];
        st_white_q[i] <= st_white_q[i-1];
        st_div_q[i]   <= st_div_q[i-1];
        st_shade_q[i] <= nx_shade[i];
        st_rem_q[i]   <= nx_rem[i];
      end
      out_x_q     <= st_x_q[DIV_STEPS];
      out_y_q     <= st_y_q[DIV_STEPS];
      out_color_q <= st_white_q[DIV_STEPS] ? COLOR_WHITE
                                           : (COLOR_ALPHA | 32'(st_shade_q[DIV_STEPS]));
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = out_x_q;
  assign pixel_y_o   = out_y_q;
  assign color_o     = out_color_q;

endmodule
`default_nettype wire

### rtl/core/zero_crossing_marker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zero_crossing_marker_top: zero crossing marker for a Q8.8 raster stream
// Configuration registers and the link of window logic, queue and shader.
// ----------------------------------------------------------------------------
// The block takes one signed Q8.8 sample per beat in raster order and, for
// every interior pixel, gives one beat with the pixel's column and row and an
// ARGB color: white when the centre and its four diagonal neighbours are all
// strictly positive or all strictly negative, otherwise opaque blue with a
// shade of floor(255*(v+band)/(2*band)) clamped to 0..255. Pixels of the
// first and last row and column give no beat. It accepts one sample every
// clock cycle while results are taken. A result passes the line stores and
// the window, the four-entry job queue, the shade divider and the result
// register, where the divider resolves one quotient bit per stage. When the
// output is stalled the queue fills and the input is stalled once the queue
// has no room left for the samples in flight. Configuration writes
// (frame_width, frame_height, zero_band) take effect at once; the sizes are
// clamped to 3..1024 and a zero band counts as one. The user must write only
// at times when no beat is in flight; the block does not enforce this. A beat
// with frame_start set restarts the raster at column and row zero; otherwise
// the position wraps after the last pixel of a frame. The line stores need no
// clearing after reset: every entry is written before it can reach a result.
// ----------------------------------------------------------------------------
module zero_crossing_marker_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [zcm_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [zcm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [zcm_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  wire logic                               frame_start_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [zcm_pkg::COL_BITS-1:0]            pixel_x_o,
  output logic [zcm_pkg::ROW_BITS-1:0]            pixel_y_o,
  output logic [31:0]                             color_o
);
  import zcm_pkg::*;

  cfg_t                     cfg_q;
  logic [DIM_BITS-1:0]      wr_dim;
  logic [BAND_BITS-1:0]     wr_band;

  logic                     push;
  job_t                     push_job;
  job_t                     head_job;
  logic                     fifo_empty;
  logic [FIFO_CNT_BITS-1:0] fifo_count;
  logic                     pop;

  assign wr_dim  = cfg_data_i[DIM_BITS-1:0];
  assign wr_band = cfg_data_i[BAND_BITS-1:0];

  // Registers hold already-clamped values so the datapath never re-checks
  // them. An index outside the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WIDTH_RESET;
      cfg_q.height <= HEIGHT_RESET;
      cfg_q.band   <= BAND_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH: begin
          cfg_q.width <= clamp_dim(wr_dim, DIM_BITS'(MAX_WIDTH));
        end
        REG_FRAME_HEIGHT: begin
          cfg_q.height <= clamp_dim(wr_dim, DIM_BITS'(MAX_HEIGHT));
        end
        REG_ZERO_BAND: begin
          cfg_q.band <= (wr_band == '0) ? BAND_BITS'(1) : wr_band;
        end
        default: begin
        end
      endcase
    end
  end

  zcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .frame_start_i (frame_start_i),
    .fifo_count_i  (fifo_count),
    .push_o        (push),
    .job_o         (push_job)
  );

  zcm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (head_job),
    .empty_o     (fifo_empty),
    .count_o     (fifo_count)
  );

  zcm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_i        (head_job),
    .fifo_empty_i (fifo_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .color_o      (color_o)
  );

endmodule
`default_nettype wire

### tb/zcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcm_checker: predicts and checks the marked pixels of the crossing marker
// Watches the configuration port and both streams, keeps its own line stores,
// window and raster position, and compares every result beat in order.
// ----------------------------------------------------------------------------
module zcm_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [zcm_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [zcm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [zcm_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic                               frame_start_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [zcm_pkg::COL_BITS-1:0]       pixel_x_i,
  input  logic [zcm_pkg::ROW_BITS-1:0]       pixel_y_i,
  input  logic [31:0]                        color_i,
  output int                                 mismatch_count_o,
  output int                                 pending_o,
  output int                                 results_o
);
  import zcm_pkg::*;

  typedef struct packed {
    logic [COL_BITS-1:0] x;
    logic [ROW_BITS-1:0] y;
    logic [31:0]         color;
  } marked_pixel_t;

  logic [DIM_BITS-1:0]           width_q;
  logic [DIM_BITS-1:0]           height_q;
  logic [BAND_BITS-1:0]          band_q;
  logic signed [SAMPLE_BITS-1:0] row_mem [2*MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] win [3][3];
  int unsigned                   col_q;
  int unsigned                   row_q;
  marked_pixel_t                 expected_marks [$];

  function automatic int unsigned limit_dim(input int unsigned value, input int unsigned hi);
    if (value < MIN_DIM) return MIN_DIM;
    if (value > hi) return hi;
    return value;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    marked_pixel_t                 want;
    string                         bad;
    int unsigned                   w;
    int unsigned                   h;
    int unsigned                   c;
    int unsigned                   r;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [SAMPLE_BITS-1:0] top_s;
    logic signed [SAMPLE_BITS-1:0] mid_s;
    logic signed [SAMPLE_BITS-1:0] centre;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic signed [SAMPLE_BITS-1:0] diag [4];
    longint                        band;
    longint                        num;
    longint                        den;
    logic [SHADE_BITS-1:0]         level;
    if (!rst_ni) begin
      width_q  = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      band_q   = BAND_RESET;
      foreach (row_mem[k]) row_mem[k] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col_q = 0;
      row_q = 0;
      expected_marks.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      results_o        = 0;
    end else begin
      // Result side first: a beat can never belong to a sample taken at this edge.
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_marks.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("[%0t] unexpected beat x=%0d y=%0d color=%08h, nothing pending",
                     $realtime, pixel_x_i, pixel_y_i, color_i);
          end
          mismatch_count_o++;
        end else begin
          want = expected_marks.pop_front();
          bad  = "";
          if (pixel_x_i !== want.x) bad = {bad, " pixel_x"};
          if (pixel_y_i !== want.y) bad = {bad, " pixel_y"};
          if (color_i !== want.color) bad = {bad, " color"};
          if (bad != "") begin
            if (mismatch_count_o < 10) begin
              $display("[%0t] mismatch in%s: expected x=%0d y=%0d color=%08h,",
                       $realtime, bad, want.x, want.y, want.color,
                       " got x=%0d y=%0d color=%08h",
                       pixel_x_i, pixel_y_i, color_i);
            end
            mismatch_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        w   = limit_dim(width_q, MAX_WIDTH);
        h   = limit_dim(height_q, MAX_HEIGHT);
        cur = sample_i;
        if (frame_start_i) begin
          col_q = 0;
          row_q = 0;
        end
        if (col_q >= w) col_q = 0;
        if (row_q >= h) row_q = 0;
        c = col_q;
        r = row_q;

        mid_s = row_mem[c];
        top_s = row_mem[MAX_WIDTH + c];
        row_mem[MAX_WIDTH + c] = mid_s;
        row_mem[c] = cur;
        for (int i = 0; i < 3; i++) begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
        win[0][2] = top_s;
        win[1][2] = mid_s;
        win[2][2] = cur;

        if (r >= 2 && c >= 2) begin
          centre  = win[1][1];
          diag[0] = win[0][0];
          diag[1] = win[0][2];
          diag[2] = win[2][0];
          diag[3] = win[2][2];
          lo = centre;
          hi = centre;
          foreach (diag[k]) begin
            if (diag[k] < lo) lo = diag[k];
            if (diag[k] > hi) hi = diag[k];
          end
          want.x = COL_BITS'(c - 1);
          want.y = ROW_BITS'(r - 1);
          if (lo > 0 || hi < 0) begin
            want.color = COLOR_WHITE;
          end else begin
            band = (band_q == '0) ? 64'sd1 : longint'(band_q);
            num  = longint'(centre) + band;
            den  = 2 * band;
            if (num <= 0) level = '0;
            else if (num >= den) level = SHADE_FULL;
            else level = SHADE_BITS'((255 * num) / den);
            want.color = COLOR_ALPHA | {24'h0, level};
          end
          expected_marks.push_back(want);
        end

        if (c + 1 >= w) begin
          col_q = 0;
          row_q = (r + 1 >= h) ? 0 : r + 1;
        end else begin
          col_q = c + 1;
        end
      end

      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_FRAME_WIDTH:  width_q  = cfg_data_i[DIM_BITS-1:0];
          REG_FRAME_HEIGHT: height_q = cfg_data_i[DIM_BITS-1:0];
          REG_ZERO_BAND:    band_q   = cfg_data_i[BAND_BITS-1:0];
          default: ;
        endcase
      end
      pending_o = expected_marks.size();
    end
  end

endmodule

### tb/zero_crossing_marker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_marker_top_tb: stimulus and verdict for the crossing marker
// Streams small raster frames of signed Q8.8 samples through the block under
// many register settings with random gaps and stalls on both sides, while a
// checker beside the block predicts and compares every marked pixel.
// ----------------------------------------------------------------------------
module zero_crossing_marker_top_tb;
  import zcm_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 12;
  // Covers the path from the completing sample to its result, plus margin.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_GAP      = 8;

  // Index 3 is not a register; a write to it must leave the block unchanged.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  // How the random samples of a frame lean: mostly positive frames and mostly
  // negative frames give many white pixels, mixed frames exercise the shading.
  typedef enum int unsigned {
    LEAN_POSITIVE,
    LEAN_NEGATIVE,
    LEAN_MIXED
  } sample_lean_e;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i    = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic [SAMPLE_BITS-1:0]   sample_i      = '0;
  logic                     frame_start_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic [COL_BITS-1:0]      pixel_x_o;
  logic [ROW_BITS-1:0]      pixel_y_o;
  logic [31:0]              color_o;

  int mismatches;
  int marks_pending;
  int marks_seen;

  // Stimulus state: the effective frame size and band of the current phase,
  // and whether either side runs without idle cycles.
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned band_now;
  int unsigned items_sent  = 0;
  int unsigned phases_run  = 0;
  logic        quiet_in    = 1'b0;
  logic        quiet_out   = 1'b0;

  // Receiver state: set for one cycle after every accepted result beat.
  logic        out_beat_seen = 1'b0;
  int unsigned out_hold_left = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  zero_crossing_marker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .color_o       (color_o)
  );

  zcm_checker mark_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .sample_i         (sample_i),
    .frame_start_i    (frame_start_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_x_i        (pixel_x_o),
    .pixel_y_i        (pixel_y_o),
    .color_i          (color_o),
    .mismatch_count_o (mismatches),
    .pending_o        (marks_pending),
    .results_o        (marks_seen)
  );

  // The result side stalls for a random number of cycles after every beat it
  // takes, so stalls land between beats of a burst as well as on full queues.
  always @(posedge clk_i) out_beat_seen <= out_valid_o && !out_stall_i;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_beat_seen) out_hold_left = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
      if (out_hold_left > 0) begin
        out_stall_i = 1'b1;
        out_hold_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results still pending", cycles, marks_pending);
    $display("Verification failed");
    $finish;
  end

  // Offers one sample beat after a random gap and holds it until accepted.
  // Called and returns at a falling edge; a gap of zero keeps valid high, so
  // back-to-back beats never lower and raise valid in the same time step.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] value, input logic first);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    sample_i      = value;
    frame_start_i = first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Waits until every predicted pixel has come out, then lets border samples
  // that cause no result leave the pipeline as well.
  task automatic drain();
    in_valid_i = 1'b0;
    while (marks_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Starts a phase: waits for the block to go idle and writes all three
  // registers. The unused upper bits of the size words carry random data,
  // which the block must ignore. Every phase then begins with frame start, so
  // the line stores are refilled under the new width before they are read.
  task automatic set_frame(input int unsigned raw_w, input int unsigned raw_h,
                           input int unsigned raw_band);
    drain();
    write_reg(REG_FRAME_WIDTH,  {4'($urandom), DIM_BITS'(raw_w)});
    write_reg(REG_FRAME_HEIGHT, {4'($urandom), DIM_BITS'(raw_h)});
    write_reg(REG_ZERO_BAND,    BAND_BITS'(raw_band));
    frame_w  = (raw_w < MIN_DIM) ? MIN_DIM : (raw_w > MAX_WIDTH) ? MAX_WIDTH : raw_w;
    frame_h  = (raw_h < MIN_DIM) ? MIN_DIM : (raw_h > MAX_HEIGHT) ? MAX_HEIGHT : raw_h;
    band_now = (raw_band == 0) ? 1 : raw_band;
    phases_run++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_lean_e lean);
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (lean != LEAN_MIXED && r < 80) begin
      v = int'($urandom_range(1, 32767));
      if (lean == LEAN_NEGATIVE) v = -v;
    end else if (r < 30 || (lean != LEAN_MIXED && r >= 90)) begin
      v = int'(16'($urandom));
    end else if (r < 80 && lean == LEAN_MIXED || r < 90) begin
      // Near zero, reaching past both ends of the shading band.
      v = int'($urandom_range(0, 4 * band_now)) - 2 * int'(band_now);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else if (r < 87) begin
      v = 32767;
    end else if (r < 94) begin
      v = -32768;
    end else begin
      v = 0;
    end
    return SAMPLE_BITS'(v);
  endfunction

  // One frame of the current size. With noise on, a rare frame start in the
  // middle restarts the raster; the window and line stores carry over.
  task automatic send_frame(input sample_lean_e lean, input logic first, input logic noisy);
    for (int unsigned i = 0; i < frame_w * frame_h; i++) begin
      push_sample(pick_sample(lean),
                  (i == 0) ? first : (noisy && $urandom_range(0, 199) == 0));
    end
  endtask

  // A 3x3 frame: one fill value, with its own centre and top left corner.
  task automatic send_grid(input logic [SAMPLE_BITS-1:0] fill,
                           input logic [SAMPLE_BITS-1:0] centre_v,
                           input logic [SAMPLE_BITS-1:0] corner_v,
                           input logic first);
    for (int i = 0; i < 9; i++) begin
      push_sample((i == 4) ? centre_v : (i == 0) ? corner_v : fill, first && i == 0);
    end
  endtask

  initial begin
    int unsigned  random_start;
    int unsigned  frames;
    int unsigned  raw_w;
    int unsigned  raw_h;
    int unsigned  raw_band;
    int unsigned  mode;
    sample_lean_e lean;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part on the smallest frame, where each frame marks one pixel.
    // All positive at the top of the range gives white.
    set_frame(3, 3, 256);
    send_grid(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    // Next frame follows without frame start; a zero corner breaks the all
    // negative case and the most negative centre shades to zero.
    send_grid(16'sh8000, 16'sh8000, 16'sh0000, 1'b0);
    // Two samples of an aborted frame, then a restart with a full shade.
    push_sample(16'sh0001, 1'b1);
    push_sample(16'sh0001, 1'b0);
    send_grid(16'sh0000, 16'sh7fff, 16'sh0000, 1'b1);

    // Out of range registers: sizes clamp to 3x3, a zero band counts as one.
    set_frame(0, 0, 0);
    write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
    for (int i = 0; i < 20; i++) send_frame(LEAN_MIXED, i == 0, 1'b0);

    // A wider frame with the widest band, then a taller frame.
    set_frame(60, 3, 32767);
    send_frame(LEAN_MIXED, 1'b1, 1'b0);
    set_frame(3, 40, $urandom_range(1, 32767));
    send_frame(LEAN_POSITIVE, 1'b1, 1'b0);

    // Random phases: mostly small frames, now and then a wider one, bands
    // from tiny to full, and a randomly chosen idling pattern for each phase.
    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      raw_w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
      raw_h = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: raw_band = $urandom_range(0, 8);
        1: raw_band = 256;
        2: raw_band = $urandom_range(9, 2048);
        default: raw_band = $urandom_range(0, 32767);
      endcase
      set_frame(raw_w, raw_h, raw_band);
      mode      = $urandom_range(0, 3);
      quiet_in  = (mode == 1 || mode == 2);
      quiet_out = (mode == 1 || mode == 3);
      frames    = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames && items_sent < random_start + RANDOM_ITEMS; f++) begin
        lean = sample_lean_e'($urandom_range(0, 2));
        send_frame(lean, (f == 0) ? 1'b1 : 1'($urandom), 1'b1);
      end
    end

    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    drain();

    $display("Streamed %0d samples over %0d register settings; %0d marked pixels checked.",
             items_sent, phases_run, marks_seen);
    $display("Frames ranged from 3x3 up to 60 columns and 40 rows, bands from 1 to 32767.");
    if (mismatches == 0 && marks_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, marks_pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/zcm_pkg.sv
rtl/core/zcm_front.sv
rtl/core/zcm_fifo.sv
rtl/core/zcm_back.sv
rtl/core/zero_crossing_marker_top.sv
tb/zcm_checker.sv
tb/zero_crossing_marker_top_tb.sv
